[hdl/atao_pkg.sv]
`timescale 1ns / 1ps
// Types and constants shared by the anchor table modules.
package atao_pkg;

   // Field widths fixed by the interface.
   localparam int OP_W      = 2;
   localparam int ID_W      = 8;
   localparam int POS_W     = 16;
   localparam int RSSI_W    = 8;
   localparam int QUAL_W    = 9;
   localparam int TIME_W    = 32;
   localparam int HITS_W    = 16;
   localparam int MINU_W    = 5;
   localparam int OUT_CNT_W = 5;
   localparam int OUT_IDX_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Quality is rssi plus these two terms when the report is usable.
   localparam int QUALITY_BASE   = 100;
   localparam int QUALITY_OFFSET = 80;

   // Register values after reset.
   localparam logic signed [RSSI_W-1:0] RSSI_THRESHOLD_RESET = -8'sd90;
   localparam logic [TIME_W-1:0]        STALE_TIMEOUT_RESET  = 32'd10000;
   localparam logic [MINU_W-1:0]        MIN_USABLE_RESET     = 5'd3;

   // Operation codes of an input item.
   typedef enum logic [OP_W-1:0] {
      OP_REPORT = 2'd0,
      OP_SWEEP  = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      REG_RSSI_THRESHOLD = 2'd0,
      REG_STALE_TIMEOUT  = 2'd1,
      REG_MIN_USABLE     = 2'd2
   } reg_index_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_RESULT = 2'd2
   } state_type;

   // One table slot.
   typedef struct packed {
      logic [ID_W-1:0]          anchor_id;
      logic [ID_W-1:0]          zone;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic signed [RSSI_W-1:0] rssi;
      logic [QUAL_W-1:0]        quality;
      logic [TIME_W-1:0]        seen_ms;
      logic [HITS_W-1:0]        hits;
      logic                     active;
   } entry_type;

   // Verdict of the evaluation unit on the slot just read.
   typedef struct packed {
      logic id_match;
      logic fresh;
      logic eligible;
      logic stronger;
   } eval_type;

endpackage

[hdl/atao_table.sv]
`timescale 1ns / 1ps
// Slot memory of the anchor table: one write port, one registered read port.
module atao_table
   import atao_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type slots_ff [DEPTH];
   entry_type rd_data_ff;

   // Write and read in the same clocked block; the read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slots_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/atao_eval.sv]
`timescale 1ns / 1ps
// Evaluation unit: judges one slot per cycle against the request and the registers.
module atao_eval
   import atao_pkg::*;
(
   input  entry_type                entry,
   input  logic [ID_W-1:0]          anchor_id,
   input  logic [TIME_W-1:0]        now_ms,
   input  logic signed [RSSI_W-1:0] rssi,
   input  logic signed [RSSI_W-1:0] rssi_threshold,
   input  logic [TIME_W-1:0]        stale_timeout_ms,
   input  logic signed [RSSI_W-1:0] best_rssi,
   input  logic                     have_best,
   output eval_type                 verdict,
   output logic [QUAL_W-1:0]        new_quality
);

   logic [TIME_W-1:0]        age;
   logic signed [QUAL_W:0]   quality_sum;

   // Age wraps with the millisecond clock.
   assign age = now_ms - entry.seen_ms;

   assign verdict.id_match = (entry.anchor_id == anchor_id);
   assign verdict.fresh    = (age <= stale_timeout_ms);
   assign verdict.eligible = entry.active && (entry.quality != '0) &&
                             (entry.rssi > rssi_threshold);
   // The first slot wins a tie, so only a strictly stronger one replaces it.
   assign verdict.stronger = !have_best || (entry.rssi > best_rssi);

   // Quality of the incoming report; zero when the report is too weak.
   assign quality_sum = {{(QUAL_W + 1 - RSSI_W){rssi[RSSI_W-1]}}, rssi} +
                        (QUAL_W + 1)'(QUALITY_BASE + QUALITY_OFFSET);
   assign new_quality = (rssi > rssi_threshold) ? quality_sum[QUAL_W-1:0] : '0;

endmodule

[hdl/atao_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the anchor table: walks the slots and builds each result.
module atao_ctrl
   import atao_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   // Command side
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_op,
   input  logic [ID_W-1:0]          req_anchor_id,
   input  logic [ID_W-1:0]          req_zone_id,
   input  logic signed [POS_W-1:0]  req_pos_x_cm,
   input  logic signed [POS_W-1:0]  req_pos_y_cm,
   input  logic signed [POS_W-1:0]  req_pos_z_cm,
   input  logic signed [RSSI_W-1:0] req_rssi,
   input  logic [TIME_W-1:0]        req_now_ms,
   input  logic [MINU_W-1:0]        min_usable,
   // Slot memory
   output logic                     wr_en,
   output logic [IDX_W-1:0]         wr_addr,
   output entry_type                wr_data,
   output logic [IDX_W-1:0]         rd_addr,
   input  entry_type                rd_data,
   // Evaluation unit
   output logic [ID_W-1:0]          cur_anchor_id,
   output logic [TIME_W-1:0]        cur_now_ms,
   output logic signed [RSSI_W-1:0] cur_rssi,
   output logic signed [RSSI_W-1:0] best_rssi,
   output logic                     have_best,
   input  eval_type                 verdict,
   input  logic [QUAL_W-1:0]        new_quality,
   // Result side
   output logic                     rsp_valid,
   output logic [OUT_IDX_W-1:0]     rsp_entry_index,
   output logic                     rsp_stored,
   output logic                     rsp_was_existing,
   output logic [OUT_CNT_W-1:0]     rsp_entry_count,
   output logic [OUT_CNT_W-1:0]     rsp_removed_count,
   output logic [OUT_CNT_W-1:0]     rsp_eligible_count,
   output logic [OUT_IDX_W-1:0]     rsp_best_index,
   output logic [ID_W-1:0]          rsp_best_anchor_id,
   output logic signed [RSSI_W-1:0] rsp_best_rssi,
   output logic [QUAL_W-1:0]        rsp_best_quality,
   output logic                     rsp_best_valid
);

   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

   state_type state_ff, state_in;

   // Latched request
   logic [OP_W-1:0]          op_ff;
   logic [ID_W-1:0]          id_ff;
   logic [ID_W-1:0]          zone_ff;
   logic signed [POS_W-1:0]  x_ff, y_ff, z_ff;
   logic signed [RSSI_W-1:0] rssi_ff;
   logic [TIME_W-1:0]        now_ff;

   // Scan state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  issue_ff;
   logic              pend_ff;
   logic [IDX_W-1:0]  eval_idx_ff;
   logic [CNT_W-1:0]  kept_ff;
   logic [CNT_W-1:0]  elig_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  slot_ff;
   logic [HITS_W-1:0] hits_ff;
   logic              have_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [ID_W-1:0]   best_id_ff;
   logic signed [RSSI_W-1:0] best_rssi_ff;
   logic [QUAL_W-1:0] best_qual_ff;

   // Result registers
   logic                     rsp_valid_ff;
   logic [OUT_IDX_W-1:0]     rsp_entry_index_ff, rsp_entry_index_in;
   logic                     rsp_stored_ff, rsp_stored_in;
   logic                     rsp_was_existing_ff, rsp_was_existing_in;
   logic [OUT_CNT_W-1:0]     rsp_entry_count_ff, rsp_entry_count_in;
   logic [OUT_CNT_W-1:0]     rsp_removed_count_ff, rsp_removed_count_in;
   logic [OUT_CNT_W-1:0]     rsp_eligible_count_ff, rsp_eligible_count_in;
   logic [OUT_IDX_W-1:0]     rsp_best_index_ff, rsp_best_index_in;
   logic [ID_W-1:0]          rsp_best_anchor_id_ff, rsp_best_anchor_id_in;
   logic signed [RSSI_W-1:0] rsp_best_rssi_ff, rsp_best_rssi_in;
   logic [QUAL_W-1:0]        rsp_best_quality_ff, rsp_best_quality_in;
   logic                     rsp_best_valid_ff, rsp_best_valid_in;

   logic accept;
   logic issue_go;
   logic scan_done;
   logic room;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign room     = (count_ff < FULL);
   assign issue_go = (state_ff == ST_SCAN) && (issue_ff < count_ff);
   // A report stops at its first match; otherwise the walk ends when the
   // last slot read has been judged.
   assign scan_done = ((op_ff == OP_REPORT) && pend_ff && verdict.id_match) ||
                      (!pend_ff && !(issue_ff < count_ff));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_REPORT || req_op == OP_SWEEP || req_op == OP_QUERY) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory control: compaction copies during a sweep, the slot write of a report.
   always_comb begin
      rd_addr = issue_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = kept_ff[IDX_W-1:0];
      wr_data = rd_data;
      unique case (state_ff)
         ST_SCAN: begin
            if (op_ff == OP_SWEEP && pend_ff && verdict.fresh &&
                kept_ff != CNT_W'(eval_idx_ff)) begin
               wr_en = 1'b1;
            end
         end
         ST_RESULT: begin
            if (op_ff == OP_REPORT && (found_ff || room)) begin
               wr_en             = 1'b1;
               wr_addr           = found_ff ? slot_ff : count_ff[IDX_W-1:0];
               wr_data.anchor_id = id_ff;
               wr_data.zone      = zone_ff;
               wr_data.pos_x     = x_ff;
               wr_data.pos_y     = y_ff;
               wr_data.pos_z     = z_ff;
               wr_data.rssi      = rssi_ff;
               wr_data.quality   = new_quality;
               wr_data.seen_ms   = now_ff;
               wr_data.hits      = found_ff ? hits_ff + HITS_W'(1) : '0;
               wr_data.active    = (new_quality != '0);
            end
         end
         default: begin
         end
      endcase
   end

   // Result fields and the entry count after the op.
   always_comb begin
      logic [31:0] wide_count;
      logic [31:0] wide_removed;
      logic [31:0] wide_elig;
      logic [31:0] wide_slot;
      logic [31:0] wide_best;

      count_in              = count_ff;
      wide_removed          = '0;
      wide_elig             = '0;
      wide_slot             = '0;
      wide_best             = '0;
      rsp_stored_in         = 1'b0;
      rsp_was_existing_in   = 1'b0;
      rsp_best_anchor_id_in = '0;
      rsp_best_rssi_in      = '0;
      rsp_best_quality_in   = '0;
      rsp_best_valid_in     = 1'b0;

      priority case (op_ff)
         OP_REPORT: begin
            if (found_ff) begin
               rsp_stored_in       = 1'b1;
               rsp_was_existing_in = 1'b1;
               wide_slot           = 32'(slot_ff);
            end else if (room) begin
               rsp_stored_in = 1'b1;
               wide_slot     = 32'(count_ff);
               count_in      = count_ff + ONE;
            end
         end
         OP_SWEEP: begin
            count_in     = kept_ff;
            wide_removed = 32'(count_ff - kept_ff);
         end
         OP_QUERY: begin
            wide_elig = 32'(elig_ff);
            if (have_ff) begin
               wide_best             = 32'(best_idx_ff);
               rsp_best_anchor_id_in = best_id_ff;
               rsp_best_rssi_in      = best_rssi_ff;
               rsp_best_quality_in   = best_qual_ff;
               rsp_best_valid_in     = (32'(elig_ff) >= 32'(min_usable)) &&
                                       (elig_ff != '0);
            end
         end
         default: begin
         end
      endcase

      wide_count             = 32'(count_in);
      rsp_entry_count_in     = wide_count[OUT_CNT_W-1:0];
      rsp_removed_count_in   = wide_removed[OUT_CNT_W-1:0];
      rsp_eligible_count_in  = wide_elig[OUT_CNT_W-1:0];
      rsp_entry_index_in     = wide_slot[OUT_IDX_W-1:0];
      rsp_best_index_in      = wide_best[OUT_IDX_W-1:0];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         kept_ff      <= '0;
         elig_ff      <= '0;
         found_ff     <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_RESULT);
         if (state_ff == ST_RESULT) begin
            count_ff <= count_in;
         end
         if (accept) begin
            issue_ff <= '0;
            pend_ff  <= 1'b0;
            kept_ff  <= '0;
            elig_ff  <= '0;
            found_ff <= 1'b0;
            have_ff  <= 1'b0;
         end else if (state_ff == ST_SCAN) begin
            pend_ff <= issue_go;
            if (issue_go) begin
               issue_ff <= issue_ff + ONE;
            end
            if (pend_ff) begin
               priority case (op_ff)
                  OP_REPORT: begin
                     if (verdict.id_match) begin
                        found_ff <= 1'b1;
                     end
                  end
                  OP_SWEEP: begin
                     if (verdict.fresh) begin
                        kept_ff <= kept_ff + ONE;
                     end
                  end
                  OP_QUERY: begin
                     if (verdict.eligible) begin
                        elig_ff <= elig_ff + ONE;
                        if (verdict.stronger) begin
                           have_ff <= 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   // Payload registers: request, slot being judged, matched slot, best candidate, result.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         id_ff   <= req_anchor_id;
         zone_ff <= req_zone_id;
         x_ff    <= req_pos_x_cm;
         y_ff    <= req_pos_y_cm;
         z_ff    <= req_pos_z_cm;
         rssi_ff <= req_rssi;
         now_ff  <= req_now_ms;
      end
      eval_idx_ff <= issue_ff[IDX_W-1:0];
      if (state_ff == ST_SCAN && pend_ff) begin
         if (op_ff == OP_REPORT && verdict.id_match) begin
            slot_ff <= eval_idx_ff;
            hits_ff <= rd_data.hits;
         end
         if (op_ff == OP_QUERY && verdict.eligible && verdict.stronger) begin
            best_idx_ff  <= eval_idx_ff;
            best_id_ff   <= rd_data.anchor_id;
            best_rssi_ff <= rd_data.rssi;
            best_qual_ff <= rd_data.quality;
         end
      end
      if (state_ff == ST_RESULT) begin
         rsp_entry_index_ff    <= rsp_entry_index_in;
         rsp_stored_ff         <= rsp_stored_in;
         rsp_was_existing_ff   <= rsp_was_existing_in;
         rsp_entry_count_ff    <= rsp_entry_count_in;
         rsp_removed_count_ff  <= rsp_removed_count_in;
         rsp_eligible_count_ff <= rsp_eligible_count_in;
         rsp_best_index_ff     <= rsp_best_index_in;
         rsp_best_anchor_id_ff <= rsp_best_anchor_id_in;
         rsp_best_rssi_ff      <= rsp_best_rssi_in;
         rsp_best_quality_ff   <= rsp_best_quality_in;
         rsp_best_valid_ff     <= rsp_best_valid_in;
      end
   end

   assign cur_anchor_id = id_ff;
   assign cur_now_ms    = now_ff;
   assign cur_rssi      = rssi_ff;
   assign best_rssi     = best_rssi_ff;
   assign have_best     = have_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_index    = rsp_entry_index_ff;
   assign rsp_stored         = rsp_stored_ff;
   assign rsp_was_existing   = rsp_was_existing_ff;
   assign rsp_entry_count    = rsp_entry_count_ff;
   assign rsp_removed_count  = rsp_removed_count_ff;
   assign rsp_eligible_count = rsp_eligible_count_ff;
   assign rsp_best_index     = rsp_best_index_ff;
   assign rsp_best_anchor_id = rsp_best_anchor_id_ff;
   assign rsp_best_rssi      = rsp_best_rssi_ff;
   assign rsp_best_quality   = rsp_best_quality_ff;
   assign rsp_best_valid     = rsp_best_valid_ff;

   // A result strobe never lasts beyond one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   // The table never holds more entries than it has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("entry count beyond table depth");

   // The slot memory is written only while an op is in progress.
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != ST_IDLE))
      else $error("slot write while idle");

   // A compaction copy always moves a slot toward the front.
   a_copy_down: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_SCAN) |-> (kept_ff < CNT_W'(eval_idx_ff)))
      else $error("sweep copy to a slot not below its source");

   // An update of an existing entry is always reported as stored.
   a_update_stored: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_was_existing_ff) |-> rsp_stored_ff)
      else $error("existing entry reported as not stored");

endmodule

[hdl/anchor_table_age_out.sv]
`timescale 1ns / 1ps
// A report, sweep or query walks the stored entries from start to the result strobe
// (a report with a match ends early); an unused op code goes straight to the result.
// A new op is accepted only when busy is low, once the last op is done; the walk is bounded
// by the single read port of the slot memory, which the sequencer walks one slot per cycle.
// The result strobe is high for one cycle and the receiver cannot stall it.
// Reset empties the table and restores the registers; slot contents are not cleared.
module anchor_table_age_out
   import atao_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // Command channel
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_op,
   input  logic [ID_W-1:0]          req_anchor_id,
   input  logic [ID_W-1:0]          req_zone_id,
   input  logic signed [POS_W-1:0]  req_pos_x_cm,
   input  logic signed [POS_W-1:0]  req_pos_y_cm,
   input  logic signed [POS_W-1:0]  req_pos_z_cm,
   input  logic signed [RSSI_W-1:0] req_rssi,
   input  logic [TIME_W-1:0]        req_now_ms,
   // Result channel
   output logic                     rsp_valid,
   output logic [OUT_IDX_W-1:0]     rsp_entry_index,
   output logic                     rsp_stored,
   output logic                     rsp_was_existing,
   output logic [OUT_CNT_W-1:0]     rsp_entry_count,
   output logic [OUT_CNT_W-1:0]     rsp_removed_count,
   output logic [OUT_CNT_W-1:0]     rsp_eligible_count,
   output logic [OUT_IDX_W-1:0]     rsp_best_index,
   output logic [ID_W-1:0]          rsp_best_anchor_id,
   output logic signed [RSSI_W-1:0] rsp_best_rssi,
   output logic [QUAL_W-1:0]        rsp_best_quality,
   output logic                     rsp_best_valid,
   // Configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic signed [RSSI_W-1:0] rssi_threshold_ff;
   logic [TIME_W-1:0]        stale_timeout_ff;
   logic [MINU_W-1:0]        min_usable_ff;
   logic                     csr_write;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   logic [ID_W-1:0]          cur_anchor_id;
   logic [TIME_W-1:0]        cur_now_ms;
   logic signed [RSSI_W-1:0] cur_rssi;
   logic signed [RSSI_W-1:0] best_rssi;
   logic                     have_best;
   eval_type                 verdict;
   logic [QUAL_W-1:0]        new_quality;

   // Configuration registers, written on the access cycle of a write transfer.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rssi_threshold_ff <= RSSI_THRESHOLD_RESET;
         stale_timeout_ff  <= STALE_TIMEOUT_RESET;
         min_usable_ff     <= MIN_USABLE_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_RSSI_THRESHOLD: rssi_threshold_ff <= pwdata[RSSI_W-1:0];
            REG_STALE_TIMEOUT:  stale_timeout_ff  <= pwdata[TIME_W-1:0];
            REG_MIN_USABLE:     min_usable_ff     <= pwdata[MINU_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (paddr[3:2])
         REG_RSSI_THRESHOLD: prdata = CSR_DATA_W'(rssi_threshold_ff);
         REG_STALE_TIMEOUT:  prdata = CSR_DATA_W'(stale_timeout_ff);
         REG_MIN_USABLE:     prdata = CSR_DATA_W'(min_usable_ff);
         default:            prdata = '0;
      endcase
   end

   atao_table #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   atao_eval u_eval (
      .entry            (rd_data),
      .anchor_id        (cur_anchor_id),
      .now_ms           (cur_now_ms),
      .rssi             (cur_rssi),
      .rssi_threshold   (rssi_threshold_ff),
      .stale_timeout_ms (stale_timeout_ff),
      .best_rssi        (best_rssi),
      .have_best        (have_best),
      .verdict          (verdict),
      .new_quality      (new_quality)
   );

   atao_ctrl #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_anchor_id      (req_anchor_id),
      .req_zone_id        (req_zone_id),
      .req_pos_x_cm       (req_pos_x_cm),
      .req_pos_y_cm       (req_pos_y_cm),
      .req_pos_z_cm       (req_pos_z_cm),
      .req_rssi           (req_rssi),
      .req_now_ms         (req_now_ms),
      .min_usable         (min_usable_ff),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .cur_anchor_id      (cur_anchor_id),
      .cur_now_ms         (cur_now_ms),
      .cur_rssi           (cur_rssi),
      .best_rssi          (best_rssi),
      .have_best          (have_best),
      .verdict            (verdict),
      .new_quality        (new_quality),
      .rsp_valid          (rsp_valid),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_stored         (rsp_stored),
      .rsp_was_existing   (rsp_was_existing),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_removed_count  (rsp_removed_count),
      .rsp_eligible_count (rsp_eligible_count),
      .rsp_best_index     (rsp_best_index),
      .rsp_best_anchor_id (rsp_best_anchor_id),
      .rsp_best_rssi      (rsp_best_rssi),
      .rsp_best_quality   (rsp_best_quality),
      .rsp_best_valid     (rsp_best_valid)
   );

endmodule
